FILE: rtl/lpl_pkg.sv
package lpl_pkg;

    // Fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_FRAC  = 16;
    localparam int GAIN_W     = GAIN_FRAC + 1;
    localparam int LEVEL_W    = SAMPLE_W - 1;
    localparam int COEF_W     = 16;
    localparam int LOOKAHEAD_W = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DELAY_DEPTH_DEF = 512;

    // Unity gain in Q1.16
    localparam logic [GAIN_W-1:0] UNITY_GAIN = GAIN_W'(1) << GAIN_FRAC;

    // Register reset values
    localparam logic [LEVEL_W-1:0]     THRESHOLD_RST = LEVEL_W'(27700);
    localparam logic [LEVEL_W-1:0]     CEILING_RST   = LEVEL_W'(30900);
    localparam logic [COEF_W-1:0]      RELEASE_RST   = COEF_W'(65530);
    localparam logic [LOOKAHEAD_W-1:0] LOOKAHEAD_RST = LOOKAHEAD_W'(288);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_CEILING   = 2'd1,
        REG_RELEASE   = 2'd2,
        REG_LOOKAHEAD = 2'd3
    } lpl_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ATTACK,
        ST_RELEASE,
        ST_MUL_L,
        ST_MUL_R,
        ST_DONE
    } lpl_state_t;

endpackage

FILE: rtl/lookahead_peak_limiter.sv
// Sequence: after an input transfer the pair passes attack, release (skipped on an
// instant attack), left and right multiply and done; above threshold the 16-step
// restoring divider runs for the gain first. A new pair is taken only in idle, once the
// last has reached the output register; the shared 18x17 multiplier serves release, left and right scaling in turn.
// Reset: async active low; gain returns to unity, delay lines read as zero through
// a fill count until written, configuration registers take their default values.
module lookahead_peak_limiter #(
    parameter int DELAY_DEPTH = lpl_pkg::DELAY_DEPTH_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write port
    input  logic                                   cfg_we,
    input  logic [lpl_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [lpl_pkg::CFG_DATA_W-1:0]         cfg_data,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [lpl_pkg::SAMPLE_W-1:0]    left_in,
    input  logic signed [lpl_pkg::SAMPLE_W-1:0]    right_in,
    // output channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [lpl_pkg::SAMPLE_W-1:0]    left_out,
    output logic signed [lpl_pkg::SAMPLE_W-1:0]    right_out,
    output logic [lpl_pkg::GAIN_W-1:0]             gain_reduction
);
    import lpl_pkg::*;

    localparam int PTR_W   = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int CMP_W   = (PTR_W + 1 > LOOKAHEAD_W) ? PTR_W + 1 : LOOKAHEAD_W;
    localparam int CNT_W   = $clog2(GAIN_FRAC);
    localparam int MA_W    = GAIN_W + 1;
    localparam int MB_W    = ((SAMPLE_W > COEF_W) ? SAMPLE_W : COEF_W) + 1;
    localparam int PROD_W  = MA_W + MB_W;

    localparam logic [CMP_W-1:0] DEPTH_C     = CMP_W'(DELAY_DEPTH);
    localparam logic [CMP_W-1:0] DEPTH_M1_C  = CMP_W'(DELAY_DEPTH - 1);
    localparam logic [PTR_W-1:0] PTR_LAST    = PTR_W'(DELAY_DEPTH - 1);
    localparam logic [CNT_W-1:0] DIV_LAST    = CNT_W'(GAIN_FRAC - 1);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    // configuration registers
    logic [LEVEL_W-1:0]     threshold_reg;
    logic [LEVEL_W-1:0]     ceiling_reg;
    logic [COEF_W-1:0]      release_reg;
    logic [LOOKAHEAD_W-1:0] lookahead_reg;

    // sequencer
    lpl_state_t state_reg, state_next;
    logic       accept;
    logic       mul_en;
    logic       load_out;

    // delay line and pointers
    logic [2*SAMPLE_W-1:0] delay_mem [DELAY_DEPTH];
    logic [2*SAMPLE_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]      wp_reg;
    logic [PTR_W-1:0]      rp_reg;
    logic [CMP_W-1:0]      fill_reg;
    logic                  rd_valid_reg;

    // datapath registers
    logic [LEVEL_W-1:0]       peak_reg;
    logic [LEVEL_W-1:0]       rem_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [GAIN_W-1:0]        target_reg;
    logic [GAIN_W-1:0]        gain_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SAMPLE_W-1:0] res_l_reg;

    // output registers
    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] left_out_reg;
    logic signed [SAMPLE_W-1:0] right_out_reg;
    logic [GAIN_W-1:0]          gr_reg;

    // saturated magnitude of a sample
    function automatic logic [LEVEL_W-1:0] mag_sat(input logic signed [SAMPLE_W-1:0] x);
        logic signed [SAMPLE_W-1:0] neg;
        neg = -x;
        if (x == SAMPLE_MIN)
            mag_sat = {LEVEL_W{1'b1}};
        else if (x[SAMPLE_W-1])
            mag_sat = neg[LEVEL_W-1:0];
        else
            mag_sat = x[LEVEL_W-1:0];
    endfunction

    // floor shift of a product, then clip to +/- ceiling
    function automatic logic signed [SAMPLE_W-1:0] clip(
        input logic signed [PROD_W-1:0] p,
        input logic [LEVEL_W-1:0]       c
    );
        logic signed [PROD_W-1:0] y;
        logic signed [PROD_W-1:0] cp;
        logic signed [PROD_W-1:0] cn;
        y  = p >>> GAIN_FRAC;
        cp = $signed(PROD_W'(c));
        cn = -cp;
        if (y > cp)
            clip = cp[SAMPLE_W-1:0];
        else if (y < cn)
            clip = cn[SAMPLE_W-1:0];
        else
            clip = y[SAMPLE_W-1:0];
    endfunction

    assign accept = in_valid && in_ready;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RST;
            ceiling_reg   <= CEILING_RST;
            release_reg   <= RELEASE_RST;
            lookahead_reg <= LOOKAHEAD_RST;
        end
        else if (cfg_we)
        begin
            unique case (lpl_reg_t'(cfg_index))
                REG_THRESHOLD: threshold_reg <= cfg_data[LEVEL_W-1:0];
                REG_CEILING:   ceiling_reg   <= cfg_data[LEVEL_W-1:0];
                REG_RELEASE:   release_reg   <= cfg_data[COEF_W-1:0];
                REG_LOOKAHEAD: lookahead_reg <= cfg_data[LOOKAHEAD_W-1:0];
            endcase
        end
    end

    // read position and fill check at transfer time
    logic [CMP_W-1:0] la_ext, la_sat, wp_ext, rp_wide, fill_new;
    logic [LEVEL_W-1:0] mag_l, mag_r, peak_new;

    always_comb
    begin
        la_ext   = CMP_W'(lookahead_reg);
        la_sat   = (la_ext >= DEPTH_C) ? DEPTH_M1_C : la_ext;
        wp_ext   = CMP_W'(wp_reg);
        rp_wide  = (wp_ext >= la_sat) ? wp_ext - la_sat : wp_ext + DEPTH_C - la_sat;
        fill_new = (fill_reg == DEPTH_C) ? fill_reg : fill_reg + CMP_W'(1);
        mag_l    = mag_sat(left_in);
        mag_r    = mag_sat(right_in);
        peak_new = (mag_r > mag_l) ? mag_r : mag_l;
    end

    // delay line memory: write on transfer, registered read every cycle
    always_ff @(posedge clk)
    begin
        if (accept)
            delay_mem[wp_reg] <= {left_in, right_in};
        rd_data_reg <= delay_mem[rp_reg];
    end

    // pointer and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            fill_reg <= '0;
        end
        else if (accept)
        begin
            wp_reg   <= (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_W'(1);
            fill_reg <= fill_new;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rp_reg       <= rp_wide[PTR_W-1:0];
            rd_valid_reg <= (la_sat < fill_new);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = (peak_new > threshold_reg) ? ST_DIV : ST_ATTACK;
            ST_DIV:
                if (cnt_reg == DIV_LAST)
                    state_next = ST_ATTACK;
            ST_ATTACK:
                state_next = (target_reg < gain_reg) ? ST_MUL_L : ST_RELEASE;
            ST_RELEASE:
                state_next = ST_MUL_L;
            ST_MUL_L:
                state_next = ST_MUL_R;
            ST_MUL_R:
                state_next = ST_DONE;
            ST_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        mul_en   = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:    in_ready = 1'b1;
            ST_ATTACK:  mul_en   = !(target_reg < gain_reg);
            ST_MUL_L:   mul_en   = 1'b1;
            ST_MUL_R:   mul_en   = 1'b1;
            ST_DONE:    load_out = !out_valid_reg || out_ready;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // restoring divider step: threshold * 2^16 / peak, one quotient bit a cycle
    logic [LEVEL_W:0]   rem_dbl;
    logic               div_ge;
    logic [LEVEL_W:0]   rem_sub;
    logic [LEVEL_W-1:0] rem_next;

    always_comb
    begin
        rem_dbl  = {rem_reg, 1'b0};
        div_ge   = rem_dbl >= {1'b0, peak_reg};
        rem_sub  = rem_dbl - {1'b0, peak_reg};
        rem_next = div_ge ? rem_sub[LEVEL_W-1:0] : rem_dbl[LEVEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            peak_reg   <= peak_new;
            rem_reg    <= threshold_reg;
            cnt_reg    <= '0;
            target_reg <= (peak_new > threshold_reg) ? '0 : UNITY_GAIN;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_reg + CNT_W'(1);
            target_reg <= {target_reg[GAIN_W-2:0], div_ge};
        end
    end

    // shared multiplier: release step, then left and right scaling
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]   prod_full;
    logic signed [SAMPLE_W-1:0] dly_l, dly_r;
    logic [GAIN_W-1:0]          diff;

    always_comb
    begin
        dly_l = rd_valid_reg ? rd_data_reg[2*SAMPLE_W-1:SAMPLE_W] : '0;
        dly_r = rd_valid_reg ? rd_data_reg[SAMPLE_W-1:0] : '0;
        diff  = target_reg - gain_reg;
        mul_a = $signed({1'b0, gain_reg});
        mul_b = $signed(MB_W'(dly_l));
        priority case (state_reg)
            ST_ATTACK:
            begin
                mul_a = $signed({1'b0, diff});
                mul_b = $signed(MB_W'(release_reg));
            end
            ST_MUL_R:
                mul_b = {{(MB_W-SAMPLE_W){dly_r[SAMPLE_W-1]}}, dly_r};
            default:
                mul_b = {{(MB_W-SAMPLE_W){dly_l[SAMPLE_W-1]}}, dly_l};
        endcase
        prod_full = mul_a * mul_b;
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= prod_full;
        if (state_reg == ST_MUL_R)
            res_l_reg <= clip(prod_reg, ceiling_reg);
    end

    // smoothed gain: instant attack, exponential release
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_reg <= UNITY_GAIN;
        else if (state_reg == ST_ATTACK && target_reg < gain_reg)
            gain_reg <= target_reg;
        else if (state_reg == ST_RELEASE)
            gain_reg <= target_reg - prod_reg[COEF_W +: GAIN_W];
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            left_out_reg  <= res_l_reg;
            right_out_reg <= clip(prod_reg, ceiling_reg);
            gr_reg        <= UNITY_GAIN - gain_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_out       = left_out_reg;
    assign right_out      = right_out_reg;
    assign gain_reduction = gr_reg;

    // checks
    a_gain_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        gain_reg <= UNITY_GAIN)
        else $error("smoothed gain above unity");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_C)
        else $error("fill count beyond delay depth");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input taken while a pair is in work");

    a_out_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($signed(left_out_reg) <= $signed({1'b0, ceiling_reg}))
                       && ($signed(left_out_reg) >= -$signed({1'b0, ceiling_reg}))
                       && ($signed(right_out_reg) <= $signed({1'b0, ceiling_reg}))
                       && ($signed(right_out_reg) >= -$signed({1'b0, ceiling_reg})))
        else $error("output beyond ceiling");

endmodule

FILE: bench/tb_lookahead_peak_limiter.sv
`timescale 1ns / 100ps

module tb_lookahead_peak_limiter;
    import lpl_pkg::*;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 150;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RAND_PHASES   = 9;
    localparam int PHASE_PAIRS   = 50;
    localparam int SAMPLE_PEAK   = 2 ** (SAMPLE_W - 1) - 1;

    // one limited output pair plus its gain reduction
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_smp;
        logic signed [SAMPLE_W-1:0] right_smp;
        logic [GAIN_W-1:0]          reduction;
    } limited_pair_t;

    typedef enum {ROW_CONFIG, ROW_PAIR} row_kind_t;

    typedef enum {LEVEL_ANY, LEVEL_QUIET, LEVEL_LOUD, LEVEL_EDGE} level_mode_t;

    // directed stimulus row: config rows carry threshold, ceiling, release, lookahead
    typedef struct {
        row_kind_t     kind;
        int            f0;
        int            f1;
        int            f2;
        int            f3;
        bit            typed;
        limited_pair_t want;
    } stim_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_ready;
    logic signed [SAMPLE_W-1:0]  left_in;
    logic signed [SAMPLE_W-1:0]  right_in;
    logic                        out_valid;
    logic                        out_ready;
    logic signed [SAMPLE_W-1:0]  left_out;
    logic signed [SAMPLE_W-1:0]  right_out;
    logic [GAIN_W-1:0]           gain_reduction;

    // limiter state mirror
    logic signed [SAMPLE_W-1:0]  left_line  [DELAY_DEPTH_DEF];
    logic signed [SAMPLE_W-1:0]  right_line [DELAY_DEPTH_DEF];
    logic [LOOKAHEAD_W-1:0]      wr_ptr;
    longint                      gain_state;
    int                          thr_cfg;
    int                          ceil_cfg;
    int                          rel_cfg;
    int                          la_cfg;

    limited_pair_t               pending_outputs [$];
    limited_pair_t               oldest_expected;
    stim_row_t                   directed_rows [$];

    int                          errors;
    int                          results_seen;
    int                          cycle_count;
    bit                          bursts_on;
    bit                          long_hold_done;

    lookahead_peak_limiter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_in        (left_in),
        .right_in       (right_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_out       (left_out),
        .right_out      (right_out),
        .gain_reduction (gain_reduction)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // detector magnitude, most negative code folds onto full scale
    function automatic longint sat_magnitude(input logic signed [SAMPLE_W-1:0] x);
        longint a;
        a = x;
        if (a < 0)
            a = -a;
        if (a > SAMPLE_PEAK)
            a = SAMPLE_PEAK;
        return a;
    endfunction

    // gain multiply with floor, then brick-wall clip
    function automatic logic signed [SAMPLE_W-1:0] scale_clip(input longint d, input longint g);
        longint y;
        y = (d * g) >>> GAIN_FRAC;
        if (y > ceil_cfg)
            y = ceil_cfg;
        else if (y < -ceil_cfg)
            y = -ceil_cfg;
        return SAMPLE_W'(y);
    endfunction

    // advance the limiter mirror by one pair and return the result it produces
    function automatic limited_pair_t limit_pair(input logic signed [SAMPLE_W-1:0] l,
                                                 input logic signed [SAMPLE_W-1:0] r);
        limited_pair_t          res;
        logic [LOOKAHEAD_W-1:0] rd_ptr;
        longint                 dl;
        longint                 dr;
        longint                 peak;
        longint                 target;
        longint                 g;
        longint                 unity;

        unity = UNITY_GAIN;
        left_line[wr_ptr]  = l;
        right_line[wr_ptr] = r;
        // read after write, so zero lookahead passes the current pair
        rd_ptr = wr_ptr - LOOKAHEAD_W'(la_cfg);
        dl = left_line[rd_ptr];
        dr = right_line[rd_ptr];
        wr_ptr = wr_ptr + 1'b1;

        peak = sat_magnitude(l);
        if (sat_magnitude(r) > peak)
            peak = sat_magnitude(r);

        if (peak > thr_cfg)
            target = (longint'(thr_cfg) << GAIN_FRAC) / peak;
        else
            target = unity;

        // instant attack, exponential release truncated toward the target
        g = gain_state;
        if (target < g)
            g = target;
        else
            g = target - (((target - g) * rel_cfg) >> COEF_W);
        if (g > unity)
            g = unity;
        if (g < 0)
            g = 0;
        gain_state = g;

        res.left_smp  = scale_clip(dl, g);
        res.right_smp = scale_clip(dr, g);
        res.reduction = GAIN_W'(unity - g);
        return res;
    endfunction

    function automatic stim_row_t pair_row(input int l, input int r);
        stim_row_t row;
        row.kind  = ROW_PAIR;
        row.f0    = l;
        row.f1    = r;
        row.f2    = 0;
        row.f3    = 0;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic stim_row_t known_row(input int l, input int r,
                                            input int el, input int er, input int eg);
        stim_row_t row;
        row = pair_row(l, r);
        row.typed = 1'b1;
        row.want.left_smp  = SAMPLE_W'(el);
        row.want.right_smp = SAMPLE_W'(er);
        row.want.reduction = GAIN_W'(eg);
        return row;
    endfunction

    function automatic stim_row_t config_row(input int thr, input int ceil_v,
                                             input int rel, input int la);
        stim_row_t row;
        row.kind  = ROW_CONFIG;
        row.f0    = thr;
        row.f1    = ceil_v;
        row.f2    = rel;
        row.f3    = la;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input level_mode_t mode);
        int mag;
        case (mode)
            LEVEL_QUIET: mag = $urandom_range(0, 4000) - 2000;
            LEVEL_LOUD: begin
                mag = $urandom_range(20000, SAMPLE_PEAK);
                if ($urandom_range(0, 1))
                    mag = -mag;
            end
            LEVEL_EDGE: begin
                case ($urandom_range(0, 3))
                    0:       mag = -SAMPLE_PEAK - 1;
                    1:       mag = SAMPLE_PEAK;
                    2:       mag = 0;
                    default: mag = -1;
                endcase
            end
            default: mag = $urandom;
        endcase
        return SAMPLE_W'(mag);
    endfunction

    // write all four registers once the block has drained
    task automatic write_regs(input int thr, input int ceil_v, input int rel, input int la);
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_THRESHOLD;
        cfg_data  <= CFG_DATA_W'(thr);
        @(negedge clk);
        cfg_index <= REG_CEILING;
        cfg_data  <= CFG_DATA_W'(ceil_v);
        @(negedge clk);
        cfg_index <= REG_RELEASE;
        cfg_data  <= CFG_DATA_W'(rel);
        @(negedge clk);
        cfg_index <= REG_LOOKAHEAD;
        cfg_data  <= CFG_DATA_W'(la);
        @(negedge clk);
        cfg_we <= 1'b0;
        thr_cfg  = thr & 'h7FFF;
        ceil_cfg = ceil_v & 'h7FFF;
        rel_cfg  = rel & 'hFFFF;
        la_cfg   = la & 'h1FF;
    endtask

    // offer one pair, record its expected result at the transfer
    task automatic send_pair(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r,
                             input bit typed, input limited_pair_t want);
        limited_pair_t predicted;
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(negedge clk);
        end
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = limit_pair(l, r);
        pending_outputs.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_outputs.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result L=%0d R=%0d GR=%0d",
                             left_out, right_out, gain_reduction);
            end
            else begin
                oldest_expected = pending_outputs.pop_front();
                if (left_out !== oldest_expected.left_smp
                    || right_out !== oldest_expected.right_smp
                    || gain_reduction !== oldest_expected.reduction) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: expected L=%0d R=%0d GR=%0d, got L=%0d R=%0d GR=%0d",
                                 results_seen, oldest_expected.left_smp,
                                 oldest_expected.right_smp, oldest_expected.reduction,
                                 left_out, right_out, gain_reduction);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // output side: ready runs, short stalls, one long hold to back up the input
    initial begin
        int stretch;
        bit level;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                level = 1'b0;
                stretch = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else if (bursts_on && $urandom_range(0, 2) == 0) begin
                level = 1'b0;
                stretch = $urandom_range(1, 15);
            end
            else begin
                level = 1'b1;
                stretch = $urandom_range(1, 24);
            end
            @(negedge clk);
            out_ready <= level;
            repeat (stretch - 1)
                @(negedge clk);
        end
    end

    // main stimulus
    initial begin
        int          thr;
        int          ceil_v;
        int          rel;
        int          la;
        int          run_left;
        level_mode_t mode;
        logic signed [SAMPLE_W-1:0] l;
        logic signed [SAMPLE_W-1:0] r;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_THRESHOLD;
        cfg_data  = '0;
        in_valid  = 1'b0;
        left_in   = '0;
        right_in  = '0;
        errors         = 0;
        results_seen   = 0;
        cycle_count    = 0;
        bursts_on      = 1'b1;
        long_hold_done = 1'b0;

        // mirror starts from the reset state
        foreach (left_line[i]) begin
            left_line[i]  = '0;
            right_line[i] = '0;
        end
        wr_ptr     = '0;
        gain_state = UNITY_GAIN;
        thr_cfg    = THRESHOLD_RST;
        ceil_cfg   = CEILING_RST;
        rel_cfg    = RELEASE_RST;
        la_cfg     = LOOKAHEAD_RST;

        // defaults: delay lines still zero, so only the gain shows
        directed_rows.push_back(known_row(0, 0, 0, 0, 0));
        directed_rows.push_back(known_row(32767, -32768, 0, 0, 10135));
        directed_rows.push_back(pair_row(-32768, 32767));
        directed_rows.push_back(pair_row(-1, 1));
        directed_rows.push_back(pair_row(21845, -21846));
        // pass-through at full scale, negative full scale clips
        directed_rows.push_back(config_row(32767, 32767, 0, 0));
        directed_rows.push_back(known_row(32767, -32768, 32767, -32767, 0));
        directed_rows.push_back(known_row(-32768, -32768, -32767, -32767, 0));
        directed_rows.push_back(pair_row(1234, -4321));
        // zero threshold and zero ceiling
        directed_rows.push_back(config_row(0, 0, 0, 0));
        directed_rows.push_back(known_row(5, -5, 0, 0, 65536));
        directed_rows.push_back(known_row(0, 0, 0, 0, 0));
        directed_rows.push_back(known_row(-32768, 0, 0, 0, 65536));
        // smallest levels, slowest release, longest lookahead
        directed_rows.push_back(config_row(1, 1, 65535, 511));
        directed_rows.push_back(pair_row(1, -1));
        directed_rows.push_back(pair_row(2, 2));
        directed_rows.push_back(pair_row(-32768, 0));
        directed_rows.push_back(pair_row(0, 0));
        directed_rows.push_back(pair_row(300, -300));
        // mid settings, one-sample lookahead
        directed_rows.push_back(config_row(16384, 20000, 60000, 1));
        directed_rows.push_back(pair_row(30000, -100));
        directed_rows.push_back(pair_row(100, -30000));
        directed_rows.push_back(pair_row(-1, -1));
        directed_rows.push_back(pair_row(0, 0));
        directed_rows.push_back(pair_row(20000, 20000));
        directed_rows.push_back(pair_row(0, 0));

        repeat (8)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CONFIG)
                write_regs(directed_rows[i].f0, directed_rows[i].f1,
                           directed_rows[i].f2, directed_rows[i].f3);
            else
                send_pair(SAMPLE_W'(directed_rows[i].f0), SAMPLE_W'(directed_rows[i].f1),
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // random phases, each with its own register setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: begin thr = 1;     ceil_v = 32767; rel = 65535; la = 0;   end
                1: begin thr = 32767; ceil_v = 1;     rel = 0;     la = 511; end
                2: begin thr = 8000;  ceil_v = 32767; rel = 65535; la = 3;   end
                default: begin
                    thr = $urandom_range(0, 1) ? $urandom_range(1, 32767)
                                               : $urandom_range(16000, 32767);
                    ceil_v = $urandom_range(0, 2) ? $urandom_range(1, 32767) : 32767;
                    rel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                      : $urandom_range(60000, 65535);
                    la = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 511);
                end
            endcase
            write_regs(thr, ceil_v, rel, la);
            bursts_on = (p % 3 != 2) && (p != RAND_PHASES - 1);

            // runs of one randomly chosen level shape loud attacks and quiet releases
            run_left = 0;
            mode = LEVEL_ANY;
            for (int n = 0; n < PHASE_PAIRS; n++) begin
                if (run_left == 0) begin
                    mode = level_mode_t'($urandom_range(0, 3));
                    run_left = $urandom_range(1, 12);
                end
                run_left--;
                l = pick_sample(mode);
                r = pick_sample(mode);
                send_pair(l, r, 1'b0, '0);
            end
        end

        // drain
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (pending_outputs.size() != 0)
            errors++;

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
